[rtl/bbg_pkg.sv]
`default_nettype none
package bbg_pkg;
	localparam int DistW = 24;
	localparam int AreaW = 23;
	localparam int WidthW = 11;
	localparam int OutCoordW = 11;
	localparam logic [7:0] WhiteLevel = 8'd255;
	localparam logic [DistW-1:0] ResetDist = 24'd900;
	localparam logic [AreaW-1:0] ResetArea = 23'd1000;
	localparam logic [WidthW-1:0] ResetWidth = 11'd50;

	typedef enum logic [1:0] {
		REG_DIST = 2'd0,
		REG_AREA = 2'd1,
		REG_WIDTH = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT_RD,
		ST_REPORT_CHK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_pixel;
		logic scan_rd;
		logic join_blob;
		logic new_blob;
		logic set_ovf;
		logic rep_rd;
		logic keep_box;
		logic emit_box;
		logic emit_last;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic white;
		logic last;
		logic idx_at_count;
		logic full;
		logic hit;
		logic pass;
		logic held;
		logic out_busy;
	} status_t;
endpackage
`default_nettype wire

[rtl/bbg_pixel_if.sv]
`default_nettype none
interface bbg_pixel_if #(parameter int CW = 11);
	logic valid;
	logic ready;
	logic [CW-1:0] column;
	logic [CW-1:0] row_index;
	logic [7:0] pixel_value;
	logic frame_end;
	modport source(output valid, column, row_index, pixel_value, frame_end, input ready);
	modport sink(input valid, column, row_index, pixel_value, frame_end, output ready);
endinterface
`default_nettype wire

[rtl/bbg_box_if.sv]
`default_nettype none
interface bbg_box_if;
	logic valid;
	logic ready;
	logic [10:0] box_min_x;
	logic [10:0] box_min_y;
	logic [10:0] box_max_x;
	logic [10:0] box_max_y;
	logic box_valid;
	logic table_overflow;
	logic last_box;
	modport source(output valid, box_min_x, box_min_y, box_max_x, box_max_y, box_valid,
		table_overflow, last_box, input ready);
	modport sink(input valid, box_min_x, box_min_y, box_max_x, box_max_y, box_valid,
		table_overflow, last_box, output ready);
endinterface
`default_nettype wire

[rtl/bbg_ram.sv]
`default_nettype none
module bbg_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/bbg_ctrl.sv]
`default_nettype none
module bbg_ctrl
	import bbg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire status_t st,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_pixel = 1'b1;
					state_d = ST_SCAN;
				end
			end
			// one table entry read per cycle; hit checked on the entry read last cycle
			ST_SCAN: begin
				if (!st.white) begin
					state_d = st.last ? ST_REPORT_RD : ST_IDLE;
				end else if (st.hit) begin
					cmd.join_blob = 1'b1;
					state_d = st.last ? ST_REPORT_RD : ST_IDLE;
				end else if (st.idx_at_count) begin
					if (st.full) begin
						cmd.set_ovf = 1'b1;
					end else begin
						cmd.new_blob = 1'b1;
					end
					state_d = st.last ? ST_REPORT_RD : ST_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_REPORT_RD: begin
				if (st.idx_at_count) begin
					// final beat: the held box with last_box, or the empty report
					if (!st.out_busy) begin
						cmd.emit_last = 1'b1;
						cmd.clear = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.rep_rd = 1'b1;
					state_d = ST_REPORT_CHK;
				end
			end
			ST_REPORT_CHK: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!st.pass) begin
					state_d = ST_REPORT_RD;
				end else if (!st.held) begin
					cmd.keep_box = 1'b1;
					state_d = ST_REPORT_RD;
				end else if (!st.out_busy) begin
					cmd.emit_box = 1'b1;
					cmd.keep_box = 1'b1;
					state_d = ST_REPORT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[rtl/bbg_datapath.sv]
`default_nettype none
module bbg_datapath
	import bbg_pkg::*;
#(
	parameter int MAX_BLOBS = 32,
	parameter int COORD_BITS = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [COORD_BITS-1:0] column,
	input wire logic [COORD_BITS-1:0] row_index,
	input wire logic [7:0] pixel_value,
	input wire logic frame_end,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [DistW-1:0] cfg_data,
	input wire cmd_t cmd,
	output status_t st,
	bbg_box_if.source box
);
	localparam int IW = $clog2(MAX_BLOBS);
	localparam int CNTW = $clog2(MAX_BLOBS + 1);
	localparam int EW = 4 * COORD_BITS;
	localparam int SQW = 2 * COORD_BITS;
	localparam int GW = SQW + 1;
	localparam int DCW = (GW > DistW) ? GW : DistW;
	localparam int ACW = (SQW > AreaW) ? SQW : AreaW;
	localparam int WCW = (COORD_BITS > WidthW) ? COORD_BITS : WidthW;

	logic [DistW-1:0] dist_q;
	logic [AreaW-1:0] area_q;
	logic [WidthW-1:0] width_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic white_q, last_q, ovf_q;
	logic [CNTW-1:0] count_q, idx_q;
	logic [IW-1:0] rd_idx_q;
	logic rd_ok_q;
	logic [EW-1:0] rdata, wdata;
	logic [IW-1:0] raddr, waddr;
	logic we;
	logic [COORD_BITS-1:0] l, t, r, b;
	logic [COORD_BITS-1:0] gx, gy;
	logic [SQW-1:0] gx_sq, gy_sq;
	logic [GW-1:0] dsq;
	logic hit;
	logic [COORD_BITS-1:0] wid, hgt;
	logic [SQW-1:0] area_s1;
	logic [COORD_BITS-1:0] wid_s1;
	logic [EW-1:0] ent_s1;
	logic ovalid_q;
	logic hold_q;
	logic [EW-1:0] hold_ent_q;
	logic emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= ResetDist;
			area_q <= ResetArea;
			width_q <= ResetWidth;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIST: dist_q <= cfg_data;
				REG_AREA: area_q <= cfg_data[AreaW-1:0];
				REG_WIDTH: width_q <= cfg_data[WidthW-1:0];
				default: ;
			endcase
		end
	end

	assign {l, t, r, b} = rdata;
	assign gx = (px_q < l) ? l - px_q : (px_q > r) ? px_q - r : '0;
	assign gy = (py_q < t) ? t - py_q : (py_q > b) ? py_q - b : '0;
	assign gx_sq = SQW'(gx) * SQW'(gx);
	assign gy_sq = SQW'(gy) * SQW'(gy);
	assign dsq = {1'b0, gx_sq} + {1'b0, gy_sq};
	assign hit = rd_ok_q && (DCW'(dsq) < DCW'(dist_q));
	assign wid = r - l;
	assign hgt = b - t;

	assign raddr = (cmd.scan_rd || cmd.rep_rd) ? idx_q[IW-1:0] : '0;
	assign we = cmd.join_blob || cmd.new_blob;
	assign waddr = cmd.join_blob ? rd_idx_q : count_q[IW-1:0];
	always_comb begin
		if (cmd.join_blob) begin
			wdata = {(px_q < l) ? px_q : l, (py_q < t) ? py_q : t,
				(px_q > r) ? px_q : r, (py_q > b) ? py_q : b};
		end else begin
			wdata = {px_q, py_q, px_q, py_q};
		end
	end

	bbg_ram #(.WIDTH(EW), .DEPTH(MAX_BLOBS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			white_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.load_pixel) begin
			px_q <= column;
			py_q <= row_index;
			white_q <= pixel_value == WhiteLevel;
			last_q <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			rd_idx_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= cmd.scan_rd || cmd.rep_rd;
			if (cmd.scan_rd || cmd.rep_rd) begin
				rd_idx_q <= idx_q[IW-1:0];
			end
			// each pixel and the report restart the index from zero
			if (cmd.load_pixel) begin
				idx_q <= '0;
			end else if ((cmd.join_blob || cmd.new_blob || cmd.set_ovf) && last_q) begin
				idx_q <= '0;
			end else if (cmd.scan_rd || cmd.rep_rd) begin
				idx_q <= idx_q + CNTW'(1);
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.new_blob) begin
				count_q <= count_q + CNTW'(1);
			end
			if (cmd.clear) begin
				ovf_q <= 1'b0;
			end else if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_ok_q) begin
			area_s1 <= SQW'(wid) * SQW'(hgt);
			wid_s1 <= wid;
			ent_s1 <= rdata;
		end
	end

	assign emit = cmd.emit_box || cmd.emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (box.ready) begin
			ovalid_q <= 1'b0;
		end
	end
	// hold one box back so last_box can be set on the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (cmd.clear) begin
			hold_q <= 1'b0;
		end else if (cmd.keep_box) begin
			hold_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.keep_box) begin
			hold_ent_q <= ent_s1;
		end
	end
	assign box.valid = ovalid_q;
	always_ff @(posedge clk) begin
		if (emit) begin
			box.table_overflow <= ovf_q;
			box.box_valid <= hold_q;
			box.last_box <= cmd.emit_last;
			{box.box_min_x, box.box_min_y, box.box_max_x, box.box_max_y} <=
				!hold_q ? '0 : {OutCoordW'(hold_ent_q[EW-1 -: COORD_BITS]),
				OutCoordW'(hold_ent_q[3*COORD_BITS-1 -: COORD_BITS]),
				OutCoordW'(hold_ent_q[2*COORD_BITS-1 -: COORD_BITS]),
				OutCoordW'(hold_ent_q[COORD_BITS-1:0])};
		end
	end

	assign st.white = white_q;
	assign st.last = last_q;
	assign st.idx_at_count = idx_q == count_q;
	assign st.full = count_q == CNTW'(MAX_BLOBS);
	assign st.hit = hit;
	assign st.pass = (ACW'(area_s1) >= ACW'(area_q)) && (WCW'(wid_s1) >= WCW'(width_q));
	assign st.held = hold_q;
	assign st.out_busy = ovalid_q && !box.ready;
endmodule
`default_nettype wire

[rtl/blob_bounding_box_grouper.sv]
// blob bounding box grouper
// pixels enter on the pix channel one beat at a time, boxes leave on the box channel
// a white pixel is compared against the blob table one entry per cycle from a single
// ram read port, until a hit or the end of the stored blobs; any other pixel skips the scan
// pix.ready is high only while idle, so one pixel is in flight at a time
// frame_end starts a report after its own pixel: each stored blob is read, its area
// multiplied into a register and then checked, and the report closes with a final beat
// a passing box is held back one entry so the final beat can carry last_box
// an empty report is one beat with box_valid low
// reset clears the blob count, overflow flag and registers to defaults
// a stalled box channel holds the report; no pixel is taken until it completes
// configuration writes take effect at the clock edge with cfg_we high
`default_nettype none
module blob_bounding_box_grouper
	import bbg_pkg::*;
#(
	parameter int MAX_BLOBS = 32,
	parameter int COORD_BITS = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [DistW-1:0] cfg_data,
	bbg_pixel_if.sink pix,
	bbg_box_if.source box
);
	cmd_t cmd;
	status_t st;

	bbg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pix.valid), .in_ready(pix.ready),
		.st(st), .cmd(cmd)
	);

	bbg_datapath #(.MAX_BLOBS(MAX_BLOBS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .column(pix.column), .row_index(pix.row_index),
		.pixel_value(pix.pixel_value), .frame_end(pix.frame_end), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .st(st), .box(box)
	);

`ifndef SYNTHESIS
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_box && cmd.emit_last)) else $error("double emit");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid && !box.ready |=> box.valid) else $error("box dropped");
	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid && !box.ready |=> $stable({box.box_min_x, box.box_min_y, box.box_max_x,
		box.box_max_y, box.box_valid, box.table_overflow, box.last_box}))
		else $error("box beat changed while stalled");
	a_join_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.join_blob && cmd.new_blob)) else $error("join and new");
`endif
endmodule
`default_nettype wire
